// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fpl_pkg.sv =====
// Types, constants and the cutoff-to-gain table of the four-pole ladder lowpass.
package fpl_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int KNOB_W      = 7;
  localparam int KNOB_LEVELS = 1 << KNOB_W;
  localparam int GAIN_W      = 16;

  // Number of cascaded one-pole stages and the history it needs.
  localparam int STAGES     = 4;
  localparam int HIST_DEPTH = STAGES + 1;
  localparam int STAGE_W    = $clog2(STAGES);

  // Gain mapping: g = GAIN_BASE + floor(GAIN_SPAN * c * c / KNOB_SQ_FULL).
  localparam longint unsigned GAIN_BASE    = 1311;
  localparam longint unsigned GAIN_SPAN    = 51118;
  localparam longint unsigned KNOB_SQ_FULL = 16129;

  // Widths inside the stage arithmetic.
  localparam int MIX_W  = SAMPLE_W + 3;     // 4*in + prev_in, signed
  localparam int DIFF_W = SAMPLE_W + 2;     // v - prev_out, signed
  localparam int OPA_W  = MIX_W;            // multiplier operand width
  localparam int PROD_W = 2 * OPA_W;
  localparam int QUOT_W = SAMPLE_W + 1;     // magnitude of a quotient

  // Division by five as a multiply by ceil(2^21 / 5) and a shift; exact for
  // magnitudes below 2^19.
  localparam int               DIV5_SHIFT = 21;
  localparam logic [OPA_W-1:0] DIV5_RECIP = OPA_W'(419431);
  localparam int               GAIN_SHIFT = GAIN_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_GAIN,
    ST_UPDATE,
    ST_FINISH
  } fpl_state_t;

  typedef struct packed {
    logic             en;
    logic             neg;
    logic [OPA_W-1:0] a;
    logic [OPA_W-1:0] b;
  } fpl_mul_req_t;

  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] prod;
  } fpl_mul_rsp_t;

  function automatic logic [KNOB_LEVELS-1:0][GAIN_W-1:0] build_gain_lut();
    logic [KNOB_LEVELS-1:0][GAIN_W-1:0] lut;
    longint unsigned                    c;
    for (int i = 0; i < KNOB_LEVELS; i++) begin
      c      = longint'(i);
      lut[i] = GAIN_W'(GAIN_BASE + (GAIN_SPAN * c * c) / KNOB_SQ_FULL);
    end
    return lut;
  endfunction

  localparam logic [KNOB_LEVELS-1:0][GAIN_W-1:0] GAIN_LUT = build_gain_lut();

endpackage

// ===== hw/rtl/fpl_if.sv =====
// Valid/ready stream interfaces for the input and result channels.
interface fpl_in_if;
  logic                       valid;
  logic                       ready;
  logic signed [15:0]         sample_in;
  logic        [6:0]          cutoff_knob;

  modport source (output valid, output sample_in, output cutoff_knob, input ready);
  modport sink   (input valid, input sample_in, input cutoff_knob, output ready);
endinterface

interface fpl_out_if;
  logic                       valid;
  logic                       ready;
  logic signed [15:0]         sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== hw/rtl/fpl_mul.sv =====
// Shared unsigned multiplier with a registered product and sign tag.
module fpl_mul import fpl_pkg::*; (
  input  logic         clk,
  input  fpl_mul_req_t req,
  output fpl_mul_rsp_t rsp
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      rsp.prod <= PROD_W'(req.a) * PROD_W'(req.b);
      rsp.neg  <= req.neg;
    end
  end

endmodule

// ===== hw/rtl/four_pole_ladder_lowpass.sv =====
// Top level of the four-pole ladder lowpass: sequencer, stage history and output register.
//
//   channel  direction  beat contents
//   din      in         sample_in (s16), cutoff_knob (u7)
//   dout     out        sample_out (s16), saturated
//
// One beat on din yields one beat on dout. The shared multiplier is used twice
// per stage (division by five, then gain), and din is not ready again from
// acceptance until every stage and the final write-back are done. The result
// waits in its own register, so the next beat is taken while dout stalls;
// only the final write-back waits for that register to drain.
// Reset clears the sequencer, the stage history and the output valid flag.
`include "assert_macros.svh"

module four_pole_ladder_lowpass import fpl_pkg::*; (
  input logic        clk,
  input logic        rst,
  fpl_in_if.sink     din,
  fpl_out_if.source  dout
);

  localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(STAGES - 1);

  fpl_state_t state, state_next;

  logic        [STAGE_W-1:0] stage;
  logic        [GAIN_W-1:0]  gain;
  // cur is the input of the stage being worked on, and after the last stage
  // the block output.
  logic signed [SAMPLE_W-1:0] cur;
  // The history rotates by one position per stage, so the previous input of
  // the current stage is always in hist[0] and its previous output in hist[1].
  logic signed [SAMPLE_W-1:0] hist [HIST_DEPTH];
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_data;

  fpl_mul_req_t mul_req;
  fpl_mul_rsp_t mul_rsp;

  logic accept, out_free;
  logic shift_hist;

  // Stage arithmetic.
  logic signed [MIX_W-1:0]    mix;
  logic        [OPA_W-1:0]    mix_mag;
  logic        [QUOT_W-1:0]   quot;
  logic signed [DIFF_W-1:0]   v_mix;
  logic signed [DIFF_W-1:0]   diff;
  logic        [OPA_W-1:0]    diff_mag;
  logic        [QUOT_W-1:0]   step_mag;
  logic signed [DIFF_W-1:0]   upd;
  logic signed [SAMPLE_W-1:0] upd_sat;

  assign accept   = din.valid && din.ready;
  assign out_free = !out_valid || dout.ready;

  // Mix: 4*in + prev_in, then its magnitude for the divide-by-five multiply.
  assign mix     = (MIX_W'(cur) <<< 2) + MIX_W'(hist[0]);
  assign mix_mag = mix[MIX_W-1] ? OPA_W'(-mix) : OPA_W'(mix);

  // The quotient comes back as a magnitude; restore the sign to get v, which
  // truncates toward zero like the integer division it replaces.
  assign quot     = mul_rsp.prod[DIV5_SHIFT +: QUOT_W];
  assign v_mix    = mul_rsp.neg ? -DIFF_W'(quot) : DIFF_W'(quot);
  assign diff     = v_mix - DIFF_W'(hist[1]);
  assign diff_mag = diff[DIFF_W-1] ? OPA_W'(-diff) : OPA_W'(diff);

  // Gain product, again a magnitude truncated toward zero.
  assign step_mag = mul_rsp.prod[GAIN_SHIFT +: QUOT_W];
  assign upd      = DIFF_W'(hist[1]) +
                    (mul_rsp.neg ? -DIFF_W'(step_mag) : DIFF_W'(step_mag));

  // Saturate to 16 bits when the top bits disagree.
  always_comb begin
    if (upd[DIFF_W-1:SAMPLE_W-1] == '0 || upd[DIFF_W-1:SAMPLE_W-1] == '1) begin
      upd_sat = upd[SAMPLE_W-1:0];
    end else if (upd[DIFF_W-1]) begin
      upd_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      upd_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (din.valid) state_next = ST_DIV;
      ST_DIV:    state_next = ST_GAIN;
      ST_GAIN:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = (stage == LAST_STAGE) ? ST_FINISH : ST_DIV;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: ready, multiplier requests and history shifts.
  always_comb begin
    din.ready   = 1'b0;
    mul_req     = '0;
    shift_hist  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        din.ready = 1'b1;
      end
      ST_DIV: begin
        mul_req.en  = 1'b1;
        mul_req.neg = mix[MIX_W-1];
        mul_req.a   = mix_mag;
        mul_req.b   = DIV5_RECIP;
      end
      ST_GAIN: begin
        mul_req.en  = 1'b1;
        mul_req.neg = diff[DIFF_W-1];
        mul_req.a   = diff_mag;
        mul_req.b   = OPA_W'(gain);
      end
      ST_UPDATE: begin
        shift_hist = 1'b1;
      end
      ST_FINISH: begin
        shift_hist = out_free;
      end
      default: begin
        din.ready = 1'b0;
      end
    endcase
  end

  fpl_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // Control state and history.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stage     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (accept) begin
        stage <= '0;
      end else if (state == ST_UPDATE && stage != LAST_STAGE) begin
        stage <= stage + 1'b1;
      end
      // The value leaving the stage (its input) goes to the tail; after
      // STAGES + 1 shifts the history is back in order.
      if (shift_hist) begin
        for (int i = 0; i < HIST_DEPTH - 1; i++) begin
          hist[i] <= hist[i+1];
        end
        hist[HIST_DEPTH-1] <= cur;
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur  <= din.sample_in;
      gain <= GAIN_LUT[din.cutoff_knob];
    end else if (state == ST_UPDATE) begin
      cur <= upd_sat;
    end
    if (state == ST_FINISH && out_free) begin
      out_data <= cur;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_data;

  // An accepted beat always starts the first division step.
  `ASSERT_NEXT(a_accept_starts, accept, state == ST_DIV, "accepted beat did not start")
  // A gain multiply always follows the divide-by-five multiply.
  `ASSERT_IMPLIES(a_gain_after_div, state == ST_GAIN, $past(state) == ST_DIV, "gain step out of order")
  // Finishing with a free output register always presents a result.
  `ASSERT_NEXT(a_finish_presents, state == ST_FINISH && out_free, dout.valid, "result not presented")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the four-pole ladder lowpass filter.
`timescale 1ns / 1ps

module testbench;
  import fpl_pkg::*;

  // The drain wait after the last result is derived from ITEM_CYCLES, the time
  // the block holds one item.
  localparam int ITEM_CYCLES = 3 * STAGES + 2;
  localparam int DRAIN_CYCLES = 4 * ITEM_CYCLES;
  localparam int PHASE_ITEMS = 400;
  // About 1600 random items plus the directed ones. This limit leaves ample
  // margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;

  // Gain mapping constants: 0.02 and 0.78 in unsigned Q0.16, and 127 squared.
  localparam longint GAIN_FLOOR = 1311;
  localparam longint GAIN_RANGE = 51118;
  localparam longint KNOB_FULL_SQ = 16129;

  logic clk;
  logic rst;

  fpl_in_if  din_ch ();
  fpl_out_if dout_ch ();

  four_pole_ladder_lowpass DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din_ch),
    .dout (dout_ch)
  );

  // Filter history of the predictor. Entry 0 is the previous block input;
  // entry s is the previous output of stage s.
  logic signed [SAMPLE_W-1:0] ladder_hist [0:STAGES];

  // Expected output samples, oldest first.
  logic signed [SAMPLE_W-1:0] pending_samples [$];

  int fail_count;
  int cycle_count;

  // Idle rates of the two sides, in percent of cycles.
  int send_idle_pct;
  int recv_stall_pct;

  // State of the random sample generator: a held level and a held cutoff,
  // so that the filter gets time to settle toward a step.
  logic signed [SAMPLE_W-1:0] held_level;
  logic [KNOB_W-1:0]          held_knob;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The cutoff value maps quadratically onto the stage gain.
  function automatic longint cutoff_gain(input logic [KNOB_W-1:0] knob);
    longint c;
    c = longint'(knob);
    return GAIN_FLOOR + (GAIN_RANGE * c * c) / KNOB_FULL_SQ;
  endfunction

  // One one-pole stage: mix the input with the previous input at 4:1, then
  // move the previous output toward the mix by the gain. SystemVerilog signed
  // division truncates toward zero, which is the rounding the block uses.
  function automatic logic signed [SAMPLE_W-1:0] pole_update(
      input longint x, input longint prev_x, input longint prev_y,
      input longint gain);
    longint mix;
    longint result;
    mix = (4 * x + prev_x) / 5;
    result = prev_y + ((mix - prev_y) * gain) / 65536;
    if (result > 32767) result = 32767;
    if (result < -32768) result = -32768;
    return SAMPLE_W'(result);
  endfunction

  // Runs one sample through the cascade, updates the history and returns the
  // output of the last stage.
  function automatic logic signed [SAMPLE_W-1:0] ladder_filter(
      input logic signed [SAMPLE_W-1:0] sample, input logic [KNOB_W-1:0] knob);
    logic signed [SAMPLE_W-1:0] now [0:STAGES];
    longint gain;
    gain = cutoff_gain(knob);
    now[0] = sample;
    for (int s = 1; s <= STAGES; s++) begin
      now[s] = pole_update(longint'(now[s-1]), longint'(ladder_hist[s-1]),
                           longint'(ladder_hist[s]), gain);
    end
    for (int s = 0; s <= STAGES; s++) ladder_hist[s] = now[s];
    return now[STAGES];
  endfunction

  // Receiver side: ready is redrawn every cycle from the current stall rate.
  always @(posedge clk) begin
    dout_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every output beat is checked against the oldest expected sample.
  always @(posedge clk) begin
    if (!rst && dout_ch.valid && dout_ch.ready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected output beat, sample_out=%0d", $time,
                 dout_ch.sample_out);
        fail_count++;
      end else begin
        logic signed [SAMPLE_W-1:0] want;
        want = pending_samples.pop_front();
        if (dout_ch.sample_out !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time,
                   want, dout_ch.sample_out);
          fail_count++;
        end
      end
    end
  end

  // Sends one beat. Idle cycles come first, with valid low; valid is left
  // high after acceptance so that back-to-back beats keep it high. The
  // expectation is formed at the edge where the beat is taken.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample,
                             input logic [KNOB_W-1:0] knob);
    while ($urandom_range(99) < send_idle_pct) begin
      din_ch.valid       <= 1'b0;
      din_ch.sample_in   <= SAMPLE_W'($urandom);
      din_ch.cutoff_knob <= KNOB_W'($urandom);
      @(posedge clk);
    end
    din_ch.valid       <= 1'b1;
    din_ch.sample_in   <= sample;
    din_ch.cutoff_knob <= knob;
    do @(posedge clk); while (!din_ch.ready);
    pending_samples.push_back(ladder_filter(sample, knob));
  endtask

  // Lowers valid in the time step of the last acceptance, so the last beat
  // is not taken twice.
  task automatic release_input();
    din_ch.valid <= 1'b0;
  endtask

  // Draws a sample for the random streams. Most beats hold a level for a
  // while, so that the four stages charge toward it; the rest are full-scale
  // jumps, small wiggles around the level and plain noise.
  task automatic next_random_beat(output logic signed [SAMPLE_W-1:0] sample,
                                  output logic [KNOB_W-1:0] knob);
    int pick;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 8) begin
      case ($urandom_range(3))
        0:       held_knob = '0;
        1:       held_knob = '1;
        default: held_knob = KNOB_W'($urandom);
      endcase
    end
    if (pick < 8) begin
      case ($urandom_range(3))
        0:       held_level = 16'sh7fff;
        1:       held_level = 16'sh8000;
        2:       held_level = '0;
        default: held_level = -16'sd1;
      endcase
    end else if (pick < 14) begin
      held_level = SAMPLE_W'($urandom);
    end
    if (pick < 60) begin
      sample = held_level;
    end else if (pick < 80) begin
      sample = held_level + SAMPLE_W'($signed($urandom_range(64)) - 32);
    end else begin
      sample = SAMPLE_W'($urandom);
    end
    // Now and then a beat with its own cutoff breaks the held setting.
    knob = ($urandom_range(99) < 10) ? KNOB_W'($urandom) : held_knob;
  endtask

  task automatic random_stream(input int n_items);
    logic signed [SAMPLE_W-1:0] sample;
    logic [KNOB_W-1:0]          knob;
    for (int i = 0; i < n_items; i++) begin
      next_random_beat(sample, knob);
      send_sample(sample, knob);
    end
  endtask

  // Full-scale steps at the fastest and slowest cutoff, alternating extremes
  // at full swing, tiny inputs at the lowest gains, a return to zero and two bit patterns.
  task automatic check_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) send_sample(16'sh7fff, 7'd127);
    repeat (4) send_sample(16'sh8000, 7'd127);
    repeat (3) send_sample(16'sh7fff, 7'd0);
    send_sample(16'sh0000, 7'd64);
    send_sample(16'sh0000, 7'd64);
    repeat (2) begin
      send_sample(16'sh7fff, 7'd127);
      send_sample(16'sh8000, 7'd127);
    end
    send_sample(-16'sd1, 7'd1);
    send_sample(16'sd1, 7'd1);
    send_sample(16'sh8000, 7'd126);
    send_sample(16'sh0000, 7'd127);
    send_sample(16'sh5555, 7'h55);
    send_sample(16'shaaaa, 7'h2a);
  endtask

  task automatic check_free_flow();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_stream(PHASE_ITEMS);
  endtask

  task automatic check_sender_gaps();
    send_idle_pct  = 77;
    recv_stall_pct = 0;
    random_stream(PHASE_ITEMS);
  endtask

  task automatic check_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 77;
    random_stream(PHASE_ITEMS);
  endtask

  task automatic check_both_idle();
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    random_stream(PHASE_ITEMS);
  endtask

  initial begin
    // Known values on every input from time zero.
    rst                = 1'b1;
    din_ch.valid       = 1'b0;
    din_ch.sample_in   = '0;
    din_ch.cutoff_knob = '0;
    dout_ch.ready      = 1'b0;
    fail_count         = 0;
    cycle_count        = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    held_level         = '0;
    held_knob          = '1;
    for (int s = 0; s <= STAGES; s++) ladder_hist[s] = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_extremes();
    check_free_flow();
    check_sender_gaps();
    check_receiver_stall();
    check_both_idle();
    release_input();

    // Let every result come out, then give the block time to show any
    // stray beat.
    recv_stall_pct = 0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
